/* rtl/ipfd_pkg.sv */
// ----------------------------------------------------------------------------
// ipfd_pkg
// Shared types, widths and the arctangent table for the polar discriminator.
// ----------------------------------------------------------------------------
package ipfd_pkg;

    localparam int SAMPLE_BITS       = 16;
    localparam int CORDIC_ITERATIONS = 16;
    localparam int GUARD_BITS        = 8;
    localparam int ATAN_ENTRIES      = 24;
    localparam int ITER_W            = 5;

    // x/y datapath: sample, guard bits, pre-rotation and cordic growth
    localparam int XY_W   = SAMPLE_BITS + GUARD_BITS + 3;
    localparam int Z_W    = 32;
    localparam int MAG_W  = 16;
    localparam int PH_W   = 16;
    localparam int SR_W   = 27;
    localparam int FREQ_W = 27;

    // magnitude gain correction, 1/K in q0.30
    localparam int                 INV_W       = 30;
    localparam logic [INV_W-1:0]   INV_GAIN    = INV_W'(652032874);
    localparam int                 XC_W        = XY_W - 1;
    localparam int                 MPROD_W     = XC_W + INV_W;
    localparam int                 MAG_SHIFT   = INV_W + GUARD_BITS;
    localparam int                 MQ_W        = MPROD_W + 1 - MAG_SHIFT;

    // frequency product: signed phase step times sample rate
    localparam int                 FP_W        = PH_W + 1 + SR_W;
    localparam int                 FQ_W        = FP_W - PH_W;
    localparam logic [FQ_W-1:0]    FREQ_LIMIT  = FQ_W'(62500000);

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic [Z_W-1:0]         z;
        logic                   mono;
        logic                   first;
        logic                   zero;
        logic [MAG_W-1:0]       mono_mag;
    } t_cell;

    // arctangent of 2^-i, 2^32 = 2pi, rounded to nearest
    function automatic logic [Z_W-1:0] atan_entry(input logic [ITER_W-1:0] idx);
        logic [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10680862;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/iq_polar_frequency_discriminator.sv */
// ----------------------------------------------------------------------------
// iq_polar_frequency_discriminator
// I/Q to magnitude, binary-angle phase and instantaneous frequency in Hz.
// ----------------------------------------------------------------------------
// Each beat passes an input register, a row of 16 cordic cells (one
// micro-rotation per cell) and four finishing stages; the cells hand data
// on every cycle, so a new sample can be taken each cycle while the output
// keeps up. A stall at the output fills the row from the far end before
// o_in_ready drops. The previous phase lives in the finishing stages, so
// samples may be streamed back to back. The mode and rate registers must
// be written with the block empty.
// ----------------------------------------------------------------------------
module iq_polar_frequency_discriminator
    import ipfd_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_i_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_q_sample,
    input  logic                          i_first_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [MAG_W-1:0]              o_magnitude,
    output logic signed [PH_W-1:0]        o_phase_angle,
    output logic signed [FREQ_W-1:0]      o_freq_hz
);

    localparam logic REG_IQ_MODE = 1'b0;
    localparam logic REG_RATE_HZ = 1'b1;

    logic            r_iq_mode;
    logic [SR_W-1:0] r_rate_hz;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iq_mode <= 1'b1;
            r_rate_hz <= SR_W'(1000000);
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                REG_IQ_MODE: r_iq_mode <= pwdata[0];
                REG_RATE_HZ: r_rate_hz <= pwdata[SR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_IQ_MODE: prdata = 32'(r_iq_mode);
            REG_RATE_HZ: prdata = 32'(r_rate_hz);
            default:     prdata = '0;
        endcase
    end

    // input stage: guard bits, pre-rotation by pi for the left half plane
    logic signed [XY_W-1:0] xi_ext, yq_ext, x_sh, y_sh;
    logic [XY_W-1:0]        xi_abs;
    t_cell                  n_prep, r_prep;
    logic                   r_prep_valid;

    logic                   c_valid [CORDIC_ITERATIONS+1];
    logic                   c_ready [CORDIC_ITERATIONS+1];
    t_cell                  c_data  [CORDIC_ITERATIONS+1];

    always_comb begin
        xi_ext = XY_W'(i_i_sample);
        yq_ext = XY_W'(i_q_sample);
        x_sh   = xi_ext <<< GUARD_BITS;
        y_sh   = yq_ext <<< GUARD_BITS;
        xi_abs = xi_ext[XY_W-1] ? XY_W'(-xi_ext) : XY_W'(xi_ext);

        n_prep.mono  = !r_iq_mode;
        n_prep.first = i_first_sample;
        n_prep.zero  = (i_i_sample == '0) && (i_q_sample == '0);
        if (|xi_abs[XY_W-1:MAG_W]) begin
            n_prep.mono_mag = '1;
        end else begin
            n_prep.mono_mag = xi_abs[MAG_W-1:0];
        end
        if (x_sh[XY_W-1]) begin
            n_prep.x = -x_sh;
            n_prep.y = -y_sh;
            n_prep.z = Z_W'(32'h8000_0000);
        end else begin
            n_prep.x = x_sh;
            n_prep.y = y_sh;
            n_prep.z = '0;
        end
    end

    assign o_in_ready = !r_prep_valid || c_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_prep_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_prep <= n_prep;
        end
    end

    assign c_valid[0] = r_prep_valid;
    assign c_data[0]  = r_prep;

    for (genvar k = 0; k < CORDIC_ITERATIONS; k++) begin : g_cell
        ipfd_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_iter  (ITER_W'(k)),
            .i_valid (c_valid[k]),
            .o_ready (c_ready[k]),
            .i_data  (c_data[k]),
            .o_valid (c_valid[k+1]),
            .i_ready (c_ready[k+1]),
            .o_data  (c_data[k+1])
        );
    end

    ipfd_post u_post (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rate_hz     (r_rate_hz),
        .i_valid       (c_valid[CORDIC_ITERATIONS]),
        .o_ready       (c_ready[CORDIC_ITERATIONS]),
        .i_data        (c_data[CORDIC_ITERATIONS]),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_magnitude   (o_magnitude),
        .o_phase_angle (o_phase_angle),
        .o_freq_hz     (o_freq_hz)
    );

endmodule

/* rtl/ipfd_cordic_cell.sv */
// ----------------------------------------------------------------------------
// ipfd_cordic_cell
// One vectoring cordic micro-rotation with its own pipeline register.
// ----------------------------------------------------------------------------
module ipfd_cordic_cell
    import ipfd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [ITER_W-1:0] i_iter,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_cell             i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output t_cell             o_data
);

    logic  r_valid;
    t_cell r_data;
    t_cell n_data;

    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;

    always_comb begin
        n_data = i_data;
        xs     = i_data.x >>> i_iter;
        ys     = i_data.y >>> i_iter;
        if (!i_data.y[XY_W-1]) begin
            n_data.x = i_data.x + ys;
            n_data.y = i_data.y - xs;
            n_data.z = i_data.z + atan_entry(i_iter);
        end else begin
            n_data.x = i_data.x - ys;
            n_data.y = i_data.y + xs;
            n_data.z = i_data.z - atan_entry(i_iter);
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* rtl/ipfd_post.sv */
// ----------------------------------------------------------------------------
// ipfd_post
// Gain correction, phase rounding, phase step and frequency scaling,
// ending in the output register.
// ----------------------------------------------------------------------------
module ipfd_post
    import ipfd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [SR_W-1:0]          i_rate_hz,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  t_cell                    i_data,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [MAG_W-1:0]         o_magnitude,
    output logic signed [PH_W-1:0]   o_phase_angle,
    output logic signed [FREQ_W-1:0] o_freq_hz
);

    logic r1_valid, r2_valid, r3_valid, r4_valid;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4    = !r4_valid || i_ready;
    assign rdy3    = !r3_valid || rdy4;
    assign rdy2    = !r2_valid || rdy3;
    assign rdy1    = !r1_valid || rdy2;
    assign o_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (rdy1) begin
                r1_valid <= i_valid;
            end
            if (rdy2) begin
                r2_valid <= r1_valid;
            end
            if (rdy3) begin
                r3_valid <= r2_valid;
            end
            if (rdy4) begin
                r4_valid <= r3_valid;
            end
        end
    end

    // stage 1: clamp x, gain product, round the angle
    logic [XC_W-1:0]    xc;
    logic [Z_W-1:0]     z_rnd;
    logic [MPROD_W-1:0] r1_prod, n1_prod;
    logic [PH_W-1:0]    r1_phase, n1_phase;
    logic               r1_mono, r1_first;
    logic [MAG_W-1:0]   r1_mono_mag;

    always_comb begin
        xc       = i_data.x[XY_W-1] ? '0 : i_data.x[XC_W-1:0];
        n1_prod  = MPROD_W'(xc) * MPROD_W'(INV_GAIN);
        z_rnd    = i_data.z + Z_W'(32'h0000_8000);
        n1_phase = (i_data.mono || i_data.zero) ? '0 : z_rnd[Z_W-1 -: PH_W];
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r1_prod     <= n1_prod;
            r1_phase    <= n1_phase;
            r1_mono     <= i_data.mono;
            r1_first    <= i_data.first;
            r1_mono_mag <= i_data.mono_mag;
        end
    end

    // stage 2: magnitude rounding, phase step against the previous sample
    logic [MPROD_W:0]        msum;
    logic [MQ_W-1:0]         mq;
    logic [MAG_W-1:0]        n2_mag, r2_mag;
    logic signed [PH_W-1:0]  n2_step, r2_step;
    logic [PH_W-1:0]         r2_phase;
    logic                    r2_nofreq;
    logic [PH_W-1:0]         r_prev_phase;

    always_comb begin
        msum = {1'b0, r1_prod} + ((MPROD_W+1)'(1) << (MAG_SHIFT - 1));
        mq   = msum[MPROD_W:MAG_SHIFT];
        if (r1_mono) begin
            n2_mag = r1_mono_mag;
        end else if (|mq[MQ_W-1:MAG_W]) begin
            n2_mag = '1;
        end else begin
            n2_mag = mq[MAG_W-1:0];
        end
        n2_step = $signed(r1_phase - r_prev_phase);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_phase <= '0;
        end else if (rdy2 && r1_valid && !r1_mono) begin
            r_prev_phase <= r1_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r1_valid) begin
            r2_mag    <= n2_mag;
            r2_step   <= n2_step;
            r2_phase  <= r1_phase;
            r2_nofreq <= r1_mono || r1_first;
        end
    end

    // stage 3: step times sample rate
    logic signed [FP_W-1:0] r3_prod;
    logic [MAG_W-1:0]       r3_mag;
    logic [PH_W-1:0]        r3_phase;
    logic                   r3_nofreq;

    always_ff @(posedge i_clk) begin
        if (rdy3 && r2_valid) begin
            r3_prod   <= FP_W'(r2_step) * $signed(FP_W'(i_rate_hz));
            r3_mag    <= r2_mag;
            r3_phase  <= r2_phase;
            r3_nofreq <= r2_nofreq;
        end
    end

    // stage 4: divide by 2^16 rounding away from zero, saturate
    logic [FP_W-1:0]   fabs;
    logic [FP_W-1:0]   fsum;
    logic [FQ_W-1:0]   fq;
    logic [FQ_W-1:0]   fsat;
    logic [FREQ_W-1:0] fmag;
    logic [FREQ_W-1:0] n4_freq;

    always_comb begin
        fabs = r3_prod[FP_W-1] ? FP_W'(-r3_prod) : FP_W'(r3_prod);
        fsum = fabs + FP_W'(32768);
        fq   = fsum[FP_W-1:PH_W];
        fsat = (fq > FREQ_LIMIT) ? FREQ_LIMIT : fq;
        fmag = fsat[FREQ_W-1:0];
        if (r3_nofreq) begin
            n4_freq = '0;
        end else if (r3_prod[FP_W-1]) begin
            n4_freq = -fmag;
        end else begin
            n4_freq = fmag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4 && r3_valid) begin
            o_magnitude   <= r3_mag;
            o_phase_angle <= $signed(r3_phase);
            o_freq_hz     <= $signed(n4_freq);
        end
    end

    assign o_valid = r4_valid;

endmodule
